### rtl/fir_filter_loaded_coefficients_assert.svh
// Assertion macros used by the filter's top-level RTL.
`ifndef FIR_FILTER_LOADED_COEFFICIENTS_ASSERT_SVH
`define FIR_FILTER_LOADED_COEFFICIENTS_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FIRLC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error(msg);

// An implication checked at every clock edge outside reset.
`define FIRLC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error(msg);

`endif

### rtl/firlc_pkg.sv
`default_nettype none

package firlc_pkg;

  // Default sizes of the filter.
  localparam int MAX_WING_DEF    = 63;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 18;

  // Fixed widths of the interface fields and the accumulator.
  localparam int ACC_W      = 64;
  localparam int WING_W     = 6;
  localparam int COEF_IDX_W = 7;

  // Register port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_WING = 1'b0;
  localparam logic [WING_W-1:0] WING_RESET = 6'd50;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic tap_we;
    logic smp_we;
    logic issue;
    logic load_out;
  } firlc_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } firlc_sts_t;

endpackage

`default_nettype wire

### rtl/firlc_dp.sv
`default_nettype none

module firlc_dp
  import firlc_pkg::*;
#(
  parameter int MAX_WING    = MAX_WING_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire firlc_cmd_t               cmd_i,
  output firlc_sts_t                    sts_o,
  input  wire        [WING_W-1:0]       wing_length_i,
  input  wire signed [SAMPLE_BITS-1:0]  sample_in_i,
  input  wire        [COEF_IDX_W-1:0]   coef_index_i,
  input  wire signed [COEF_BITS-1:0]    coef_value_i,
  input  wire                           out_stall_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o
);

  localparam int DELAY_LEN = 2 * MAX_WING + 1;
  localparam int TAP_DEPTH = 2 * MAX_WING + 2;
  localparam int DLY_AW    = $clog2(DELAY_LEN);
  localparam int TAP_AW    = $clog2(TAP_DEPTH);
  localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
  localparam int SHIFT     = COEF_BITS - 2;

  // Delay line as a circular buffer; a slot not yet written reads as zero.
  logic        [SAMPLE_BITS-1:0] dly_mem [DELAY_LEN];
  logic        [DELAY_LEN-1:0]   dly_vld_q;
  logic        [COEF_BITS-1:0]   tap_mem [TAP_DEPTH];

  logic        [DLY_AW-1:0]      wr_ptr_q;
  logic        [DLY_AW-1:0]      rd_ptr_q;
  logic        [TAP_AW-1:0]      tap_cnt_q;
  logic        [TAP_AW-1:0]      last_idx;

  logic        [SAMPLE_BITS-1:0] dly_q;
  logic                          dly_hit_q;
  logic signed [COEF_BITS-1:0]   tap_q;
  logic                          s1_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic                          s2_q;
  logic signed [ACC_W-1:0]       acc_q;

  logic signed [SAMPLE_BITS-1:0] x_op;
  logic                          tap_in_range;

  logic signed [ACC_W-1:0]       rnd_s;
  logic signed [ACC_W-1:0]       q_s;
  logic        [ACC_W-SAMPLE_BITS:0] q_hi;
  logic                          fits;
  logic signed [SAMPLE_BITS-1:0] res_val;

  assign last_idx = (32'(wing_length_i) > 32'(MAX_WING)) ? TAP_AW'(2 * MAX_WING)
                                                          : TAP_AW'({wing_length_i, 1'b0});
  assign tap_in_range = 32'(coef_index_i) < 32'(TAP_DEPTH);

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_we) begin
      dly_mem[wr_ptr_q] <= sample_in_i;
    end
    if (cmd_i.issue) begin
      dly_q <= dly_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_we && tap_in_range) begin
      tap_mem[TAP_AW'(coef_index_i)] <= coef_value_i;
    end
    if (cmd_i.issue) begin
      tap_q <= tap_mem[tap_cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_vld_q <= '0;
      dly_hit_q <= 1'b0;
    end else begin
      if (cmd_i.smp_we) begin
        dly_vld_q[wr_ptr_q] <= 1'b1;
      end
      if (cmd_i.issue) begin
        dly_hit_q <= dly_vld_q[rd_ptr_q];
      end
    end
  end

  // Pointers and the multiply-accumulate pipeline.
  assign x_op = dly_hit_q ? signed'(dly_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      tap_cnt_q <= '0;
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
    end else begin
      s1_q <= cmd_i.issue;
      s2_q <= s1_q;
      if (cmd_i.smp_we) begin
        rd_ptr_q  <= wr_ptr_q;
        tap_cnt_q <= '0;
        wr_ptr_q  <= (wr_ptr_q == DLY_AW'(DELAY_LEN - 1)) ? '0 : wr_ptr_q + 1'b1;
      end else if (cmd_i.issue) begin
        // Walk from the newest sample toward older ones.
        rd_ptr_q  <= (rd_ptr_q == '0) ? DLY_AW'(DELAY_LEN - 1) : rd_ptr_q - 1'b1;
        tap_cnt_q <= tap_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      prod_q <= x_op * tap_q;
    end
    if (cmd_i.smp_we) begin
      acc_q <= '0;
    end else if (s2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up, then saturate to the sample range.
  always_comb begin
    rnd_s = acc_q + (ACC_W'(1) << (SHIFT - 1));
    q_s   = rnd_s >>> SHIFT;
    q_hi  = q_s[ACC_W-1:SAMPLE_BITS-1];
    fits  = (&q_hi) || !(|q_hi);
    if (fits) begin
      res_val = q_s[SAMPLE_BITS-1:0];
    end else if (q_s[ACC_W-1]) begin
      res_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_out_o <= res_val;
      clipped_o    <= !fits;
    end
  end

  assign sts_o.last_tap  = (tap_cnt_q == last_idx);
  assign sts_o.pipe_busy = s1_q || s2_q;
  assign sts_o.out_free  = !out_valid_o || !out_stall_i;

endmodule

`default_nettype wire

### rtl/firlc_ctrl.sv
`default_nettype none

module firlc_ctrl
  import firlc_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  wire             action_i,
  output logic            in_stall_o,
  input  wire firlc_sts_t sts_i,
  output firlc_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (action_i) begin
            cmd_o.tap_we = 1'b1;
          end else begin
            cmd_o.smp_we = 1'b1;
            state_d      = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_tap) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/fir_filter_loaded_coefficients.sv
// Coefficient load: no result; the next transfer can be taken the cycle after.
// Audio sample: one multiply-accumulate per tap through a single multiplier, over
// taps 0 to 2N for N = wing_length (capped at MAX_WING); no new transfer is taken
// until the result has been loaded into the output register.
// Reset clears the delay line to zero at once and sets wing_length to 50; the tap
// memory holds no reset value and must be loaded before samples are sent.
`default_nettype none

`include "fir_filter_loaded_coefficients_assert.svh"

module fir_filter_loaded_coefficients
  import firlc_pkg::*;
#(
  parameter int MAX_WING    = MAX_WING_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Register port
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire        [APB_AW-1:0]       paddr,
  input  wire        [APB_DW-1:0]       pwdata,
  output logic       [APB_DW-1:0]       prdata,
  output logic                          pready,
  // Input items
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           action_i,
  input  wire signed [SAMPLE_BITS-1:0]  sample_in_i,
  input  wire        [COEF_IDX_W-1:0]   coef_index_i,
  input  wire signed [COEF_BITS-1:0]    coef_value_i,
  // Results
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o
);

  logic [WING_W-1:0] wing_length_q;
  logic              reg_sel;
  firlc_cmd_t        cmd;
  firlc_sts_t        sts;

  assign reg_sel = (paddr[APB_AW-1:2] == REG_WING);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(APB_DW-WING_W){1'b0}}, wing_length_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wing_length_q <= WING_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      wing_length_q <= pwdata[WING_W-1:0];
    end
  end

  firlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  firlc_dp #(
    .MAX_WING    (MAX_WING),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .wing_length_i (wing_length_q),
    .sample_in_i   (sample_in_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .sample_out_o  (sample_out_o),
    .clipped_o     (clipped_o)
  );

  `FIRLC_ASSERT_ALWAYS(a_no_issue_on_write, clk_i, rst_ni, !(cmd.issue && cmd.smp_we), "tap read issued while a sample is written")
  `FIRLC_ASSERT_ALWAYS(a_load_after_drain, clk_i, rst_ni, !(cmd.load_out && sts.pipe_busy), "result loaded before the accumulator drained")
  `FIRLC_ASSERT_IMPL(a_sample_blocks, clk_i, rst_ni, (in_valid_i && !in_stall_o && !action_i) |=> in_stall_o, "new transfer taken while a sample is in progress")
  `FIRLC_ASSERT_IMPL(a_result_from_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd.load_out), "result appeared without a load")

endmodule

`default_nettype wire

### bench/tb_fir_filter_loaded_coefficients.sv
`default_nettype none

module tb_fir_filter_loaded_coefficients;
  timeunit 1ns;
  timeprecision 1ps;

  import firlc_pkg::*;

  localparam int SW        = SAMPLE_BITS_DEF;
  localparam int CW        = COEF_BITS_DEF;
  localparam int FRAC      = CW - 2;
  localparam int DELAY_LEN = 2 * MAX_WING_DEF + 1;
  localparam int TAP_DEPTH = 2 * MAX_WING_DEF + 2;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  localparam int COEF_FULL = 0;
  localparam int COEF_MILD = 1;
  localparam int COEF_KEEP = 2;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [CW-1:0] COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COEF_MIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COEF_ONE   = CW'(1 << FRAC);
  localparam logic signed [CW-1:0] COEF_HALF  = CW'(1 << (FRAC - 1));

  localparam int LATENCY_CYCLES = 2 * MAX_WING_DEF + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 500;
  localparam int HOLD_AFTER     = 300;
  localparam int PHASE_ITEMS    = 140;

  typedef struct {
    logic                 action;
    logic signed [SW-1:0] sample;
    logic [COEF_IDX_W-1:0] index;
    logic signed [CW-1:0] coef;
  } filter_input_t;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 clipped;
  } filtered_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [APB_AW-1:0]      paddr        = '0;
  logic [APB_DW-1:0]      pwdata       = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic                   action_i     = ACT_SAMPLE;
  logic signed [SW-1:0]   sample_in_i  = '0;
  logic [COEF_IDX_W-1:0]  coef_index_i = '0;
  logic signed [CW-1:0]   coef_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic signed [SW-1:0]   sample_out_o;
  logic                   clipped_o;

  // Shadow copy of the filter state, updated in transfer order.
  logic signed [SW-1:0]   delay_line [DELAY_LEN];
  logic signed [CW-1:0]   tap_mem [TAP_DEPTH];
  logic [WING_W-1:0]      wing_cfg = WING_RESET;

  filter_input_t feed_q[$];
  filtered_t     filtered_q[$];
  filter_input_t cur_item;

  int gap_left     = 0;
  int stall_left   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int fail_count   = 0;
  bit burst_mode   = 1'b0;
  bit hold_done    = 1'b0;

  fir_filter_loaded_coefficients dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int k = 0; k < DELAY_LEN; k++) delay_line[k] = '0;
    for (int k = 0; k < TAP_DEPTH; k++) tap_mem[k] = '0;
  end

  // Shifts one sample into the delay line and returns the rounded, saturated output.
  function automatic filtered_t filter_sample(input logic signed [SW-1:0] x);
    filtered_t r;
    longint    acc;
    longint    rounded;
    int        taps;
    for (int k = DELAY_LEN - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
    delay_line[0] = x;
    taps = 2 * ((wing_cfg > MAX_WING_DEF) ? MAX_WING_DEF : int'(wing_cfg)) + 1;
    acc = 0;
    for (int j = 0; j < taps; j++) acc += longint'(delay_line[j]) * longint'(tap_mem[j]);
    // Round half up, then drop the extra coefficient fraction bits.
    rounded = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    r.clipped = 1'b1;
    if (rounded > longint'(SAMPLE_MAX)) r.sample = SAMPLE_MAX;
    else if (rounded < longint'(SAMPLE_MIN)) r.sample = SAMPLE_MIN;
    else begin
      r.sample  = SW'(rounded);
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [CW-1:0] pick_coef(input int style, input int taps);
    int lim;
    if (style == COEF_MILD) begin
      // Bounds the sum of tap magnitudes to twice unity gain so that most outputs stay in range.
      lim = (1 << (CW - 1)) / taps;
      if (lim > int'(COEF_MAX)) lim = int'(COEF_MAX);
      return CW'(int'($urandom_range(0, 2 * lim)) - lim);
    end
    return CW'($urandom);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return SAMPLE_MAX;
    if (r < 20) return SAMPLE_MIN;
    if (r < 40) return SW'(int'($urandom_range(0, 4096)) - 2048);
    return SW'($urandom);
  endfunction

  function automatic void push_load(input int idx, input logic signed [CW-1:0] value);
    filter_input_t it;
    it.action = ACT_LOAD;
    it.sample = SW'($urandom);
    it.index  = COEF_IDX_W'(idx);
    it.coef   = value;
    feed_q.push_back(it);
  endfunction

  function automatic void push_sample(input logic signed [SW-1:0] x);
    filter_input_t it;
    it.action = ACT_SAMPLE;
    it.sample = x;
    it.index  = COEF_IDX_W'($urandom);
    it.coef   = CW'($urandom);
    feed_q.push_back(it);
  endfunction

  // A fresh tap set for the taps in use (unless kept), then samples with stray loads.
  task automatic queue_phase(input int n_items);
    int style;
    int taps;
    taps  = 2 * int'(wing_cfg) + 1;
    style = $urandom_range(COEF_FULL, COEF_KEEP);
    burst_mode = ($urandom_range(0, 3) == 0);
    if (style != COEF_KEEP) begin
      for (int j = 0; j < taps; j++) push_load(j, pick_coef(style, taps));
    end
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        push_load($urandom_range(0, TAP_DEPTH - 1),
                  pick_coef((style == COEF_KEEP) ? COEF_FULL : style, taps));
      end else begin
        push_sample(pick_sample());
      end
    end
  endtask

  // Returns once every item is taken and every result has come back, plus a margin.
  task automatic settle();
    while (feed_q.size() != 0 || in_valid_i || filtered_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_wing(input logic [WING_W-1:0] w);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WING, 2'b00};
    pwdata  <= APB_DW'(w);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    wing_cfg = w;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[WING_W-1:0] !== w) begin
      $display("%0t: wing_length read back expected %0d, got %0d", $time, w,
               prdata[WING_W-1:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int w;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every tap must hold a value before the first sample goes in.
    for (int j = 0; j < TAP_DEPTH; j++) begin
      if (j == 0) push_load(j, COEF_MAX);
      else if (j == 1) push_load(j, COEF_MIN);
      else if (j == TAP_DEPTH - 1) push_load(j, CW'($urandom));
      else push_load(j, '0);
    end
    // Full-scale inputs against extreme taps saturate in both directions.
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    push_sample(SW'(1));
    push_sample(-SW'(1));
    // Unity gain passes the input through.
    push_load(0, COEF_ONE);
    push_load(1, '0);
    push_sample(SW'(12345));
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);
    // A gain of one half lands exactly on the rounding midpoint for odd inputs.
    push_load(0, COEF_HALF);
    push_sample(SW'(1));
    push_sample(-SW'(1));
    push_sample(SW'(3));
    push_sample(-SW'(3));
    // The most negative tap times the most negative sample overflows upward.
    push_load(0, COEF_MIN);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);
    settle();

    program_wing('0);
    queue_phase(PHASE_ITEMS);
    settle();
    program_wing(WING_W'(MAX_WING_DEF));
    queue_phase(PHASE_ITEMS);
    settle();
    program_wing(WING_W'(1));
    queue_phase(PHASE_ITEMS);
    settle();
    repeat (9) begin
      if ($urandom_range(0, 4) == 0) w = $urandom_range(9, MAX_WING_DEF);
      else w = $urandom_range(1, 8);
      program_wing(WING_W'(w));
      queue_phase(PHASE_ITEMS);
      settle();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Input driver: the model is updated at the edge where the transfer happens.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (cur_item.action == ACT_LOAD) tap_mem[cur_item.index] = cur_item.coef;
        else filtered_q.push_back(filter_sample(cur_item.sample));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (feed_q.size() != 0) begin
          cur_item = feed_q.pop_front();
          in_valid_i   <= 1'b1;
          action_i     <= cur_item.action;
          sample_in_i  <= cur_item.sample;
          coef_index_i <= cur_item.index;
          coef_value_i <= cur_item.coef;
          gap_left     <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold so that the block backs up its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_done   <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
      stall_left  <= LONG_HOLD - 1;
    end else if (!burst_mode && $urandom_range(0, 99) < 30) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    filtered_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result sample_out %0d clipped %0b", $time, sample_out_o,
                 clipped_o);
        fail_count++;
      end else begin
        want = filtered_q.pop_front();
        if (sample_out_o !== want.sample) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, want.sample, sample_out_o);
          fail_count++;
        end
        if (clipped_o !== want.clipped) begin
          $display("%0t: clipped expected %0b, got %0b", $time, want.clipped, clipped_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, filtered_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire
